[src/dorb_pkg.sv]
// dorb_pkg: shared constants, codes and control/status structs for the
// open-row buffer controller. No dependencies.
package dorb_pkg;

  // Geometry: both counts are powers of two.
  localparam int ROW_COUNT     = 1024;
  localparam int WORDS_PER_ROW = 256;

  localparam int ROW_W   = $clog2(ROW_COUNT);
  localparam int COL_W   = $clog2(WORDS_PER_ROW);
  localparam int ARR_AW  = ROW_W + COL_W;
  localparam int ROW_SH  = COL_W + 2;
  localparam logic [31:0] ARRAY_BYTES = 32'(ROW_COUNT * WORDS_PER_ROW * 4);

  localparam int DELAY_W  = 10;
  localparam int CYCLES_W = 12;

  // Request kinds
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_RANGE     = 2'd1;
  localparam logic [1:0] STATUS_UNALIGNED = 2'd2;

  // Configuration register indexes
  localparam logic REG_ROW_DELAY = 1'b0;
  localparam logic REG_COL_DELAY = 1'b1;

  localparam logic [DELAY_W-1:0] ROW_DELAY_RST = DELAY_W'(10);
  localparam logic [DELAY_W-1:0] COL_DELAY_RST = DELAY_W'(2);

  typedef struct packed {
    logic capture;   // take the input item
    logic cnt_clr;   // restart the sweep counter
    logic clear_en;  // reset-time clearing pass step
    logic wb_en;     // row buffer to array sweep step
    logic ld_en;     // array to row buffer sweep step
    logic col_en;    // column access
    logic finish;    // commit state, load the result register
  } ctl_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic access_ok;
    logic row_hit;
    logic row_open;
    logic sweep_last;
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

[src/dorb_ctrl.sv]
// dorb_ctrl: sequencer for clearing, writeback, row load and column access.
// Depends on dorb_pkg.
module dorb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dorb_pkg::dp_status_t sts_i,
  output dorb_pkg::ctl_cmd_t  cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_LD    = 3'd4;
  localparam logic [2:0] S_COL   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.is_flush) begin
          state_d = sts_i.row_open ? S_WB : S_FIN;
        end else if (sts_i.access_ok) begin
          if (sts_i.row_hit) begin
            state_d = S_COL;
          end else begin
            state_d = sts_i.row_open ? S_WB : S_LD;
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_WB: begin
        cmd_o.wb_en = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = sts_i.is_flush ? S_FIN : S_LD;
        end
      end
      S_LD: begin
        cmd_o.ld_en = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_COL;
        end
      end
      S_COL: begin
        cmd_o.col_en = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[src/dorb_datapath.sv]
// dorb_datapath: item registers, DRAM array and row buffer memories, sweep
// counter, bank state and result register. Depends on dorb_pkg.
module dorb_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dorb_pkg::ctl_cmd_t           cmd_i,
  output dorb_pkg::dp_status_t         sts_o,
  input  logic [dorb_pkg::DELAY_W-1:0] row_delay_i,
  input  logic [dorb_pkg::DELAY_W-1:0] col_delay_i,
  input  logic [1:0]                   func_i,
  input  logic [31:0]                  address_i,
  input  logic [31:0]                  write_data_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [31:0]                  read_data_o,
  output logic                         row_hit_o,
  output logic [dorb_pkg::CYCLES_W-1:0] service_cycles_o,
  output logic [31:0]                  update_count_o
);

  localparam int COL_W  = dorb_pkg::COL_W;
  localparam int ROW_W  = dorb_pkg::ROW_W;
  localparam int ARR_AW = dorb_pkg::ARR_AW;
  localparam int CYC_W  = dorb_pkg::CYCLES_W;

  // Item registers
  logic [1:0]  func_q;
  logic [31:0] addr_q, wdata_q;

  // Bank state
  logic [ROW_W-1:0] open_row_q;
  logic             row_open_q;
  logic [31:0]      updates_q;

  // Sweep / clearing counter
  logic [ARR_AW-1:0] cnt_q;

  // Memories
  logic [31:0] dram_mem [dorb_pkg::ROW_COUNT*dorb_pkg::WORDS_PER_ROW];
  logic [31:0] rowbuf_mem [dorb_pkg::WORDS_PER_ROW];
  logic [31:0] arr_rd_q, buf_rd_q;

  // Result register
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [31:0]         rdata_q;
  logic                hit_q;
  logic [CYC_W-1:0]    cycles_q;
  logic [31:0]         count_q;

  // Decode of the held item
  logic             is_rw, is_flush, is_write, range_err, align_err, access_ok, hit;
  logic [1:0]       status_c;
  logic [ROW_W-1:0] row_c;
  logic [COL_W-1:0] col_c, sweep_idx, prev_idx;
  logic             sweep_wr;

  assign is_flush  = (func_q == dorb_pkg::FUNC_FLUSH);
  assign is_write  = (func_q == dorb_pkg::FUNC_WRITE);
  assign is_rw     = (func_q == dorb_pkg::FUNC_READ) || is_write;
  assign range_err = addr_q[31] || (addr_q >= dorb_pkg::ARRAY_BYTES);
  assign align_err = (addr_q[1:0] != 2'b00);
  assign access_ok = is_rw && !range_err && !align_err;
  assign row_c     = addr_q[dorb_pkg::ROW_SH +: ROW_W];
  assign col_c     = addr_q[2 +: COL_W];
  assign hit       = row_open_q && (open_row_q == row_c);

  always_comb begin
    status_c = dorb_pkg::STATUS_OK;
    if (is_rw && range_err) begin
      status_c = dorb_pkg::STATUS_RANGE;
    end else if (is_rw && align_err) begin
      status_c = dorb_pkg::STATUS_UNALIGNED;
    end
  end

  // Sweep: read at cnt, write the registered word from the previous read at cnt-1
  assign sweep_idx = cnt_q[COL_W-1:0];
  assign prev_idx  = sweep_idx - COL_W'(1);
  assign sweep_wr  = (cnt_q[COL_W:0] != '0);

  assign sts_o.is_flush   = is_flush;
  assign sts_o.access_ok  = access_ok;
  assign sts_o.row_hit    = hit;
  assign sts_o.row_open   = row_open_q;
  assign sts_o.sweep_last = (cnt_q[COL_W:0] == (COL_W+1)'(dorb_pkg::WORDS_PER_ROW));
  assign sts_o.clear_last = (cnt_q == '1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.clear_en || cmd_i.wb_en || cmd_i.ld_en) begin
      cnt_q <= cnt_q + ARR_AW'(1);
    end
  end

  // DRAM array: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      dram_mem[cnt_q] <= '0;
    end else if (cmd_i.wb_en && sweep_wr) begin
      dram_mem[{open_row_q, prev_idx}] <= buf_rd_q;
    end
    arr_rd_q <= dram_mem[{row_c, sweep_idx}];
  end

  // Row buffer: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      rowbuf_mem[sweep_idx] <= '0;
    end else if (cmd_i.ld_en && sweep_wr) begin
      rowbuf_mem[prev_idx] <= arr_rd_q;
    end else if (cmd_i.col_en && is_write) begin
      rowbuf_mem[col_c] <= wdata_q;
    end
    buf_rd_q <= rowbuf_mem[cmd_i.wb_en ? sweep_idx : col_c];
  end

  // Commit
  logic             wb_done, act_done;
  logic [31:0]      updates_n;
  logic [CYC_W-1:0] cycles_c;

  assign act_done  = access_ok && !hit;
  assign wb_done   = (is_flush || act_done) && row_open_q;
  assign updates_n = updates_q + 32'(act_done) + 32'(access_ok && is_write);
  assign cycles_c  = (wb_done   ? CYC_W'(row_delay_i) : '0)
                   + (act_done  ? CYC_W'(row_delay_i) : '0)
                   + (access_ok ? CYC_W'(col_delay_i) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_row_q <= '0;
      row_open_q <= 1'b0;
      updates_q  <= '0;
    end else if (cmd_i.finish) begin
      updates_q <= updates_n;
      if (access_ok) begin
        open_row_q <= row_c;
        row_open_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q <= status_c;
      rdata_q  <= (access_ok && !is_write) ? buf_rd_q : '0;
      hit_q    <= access_ok && hit;
      cycles_q <= cycles_c;
      count_q  <= updates_n;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign read_data_o      = rdata_q;
  assign row_hit_o        = hit_q;
  assign service_cycles_o = cycles_q;
  assign update_count_o   = count_q;

endmodule

[src/dram_open_row_buffer_controller_unit.sv]
// Top level: open-page DRAM bank with one row buffer, stream in/out, APB config.
// Flow: decode; hit: column access; miss: writeback if a row is open, load, column
// access; flush: writeback if a row is open; errors, ignored codes: to the result.
// Throughput: one item at a time; the row sweeps, one word per memory cycle, set it.
// Reset: array and row buffer cleared by a pass over all 262144 words (no item taken).
// Depends on dorb_pkg, dorb_ctrl, dorb_datapath.
module dram_open_row_buffer_controller_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // address[31:0], write_data[63:32]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // read_data[31:0], service_cycles[43:32],
                                      // update_count[75:44], zero[79:76]
  output logic [2:0]  m_axis_tuser,   // status[1:0], row_hit[2]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dorb_pkg::ctl_cmd_t   cmd;
  dorb_pkg::dp_status_t sts;

  // Configuration registers: row_delay at 0x0, col_delay at 0x4
  logic [dorb_pkg::DELAY_W-1:0] row_delay_q, col_delay_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_delay_q <= dorb_pkg::ROW_DELAY_RST;
      col_delay_q <= dorb_pkg::COL_DELAY_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == dorb_pkg::REG_ROW_DELAY) begin
        row_delay_q <= pwdata[dorb_pkg::DELAY_W-1:0];
      end else begin
        col_delay_q <= pwdata[dorb_pkg::DELAY_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == dorb_pkg::REG_ROW_DELAY) begin
      prdata = 32'(row_delay_q);
    end else begin
      prdata = 32'(col_delay_q);
    end
  end

  // Sequencer: clearing pass, writeback, load, column access, result hand-off
  dorb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  logic [1:0]                    status;
  logic [31:0]                   read_data;
  logic                          row_hit;
  logic [dorb_pkg::CYCLES_W-1:0] service_cycles;
  logic [31:0]                   update_count;

  // Memories, bank state and the result register (which parts the two sides)
  dorb_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .row_delay_i      (row_delay_q),
    .col_delay_i      (col_delay_q),
    .func_i           (s_axis_tuser),
    .address_i        (s_axis_tdata[31:0]),
    .write_data_i     (s_axis_tdata[63:32]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .status_o         (status),
    .read_data_o      (read_data),
    .row_hit_o        (row_hit),
    .service_cycles_o (service_cycles),
    .update_count_o   (update_count)
  );

  assign m_axis_tdata = {4'b0000, update_count, service_cycles, read_data};
  assign m_axis_tuser = {row_hit, status};

endmodule
